### design/ppmd_pkg.sv
// Package for the PPM pulse channel decoder: reset values, queue sizing,
// configuration register indexes and the types passed between the modules.
// It depends on nothing else.
package ppmd_pkg;

   localparam int NUM_CHANNELS_DEFAULT = 8;
   localparam int QUEUE_DEPTH          = 2;

   localparam logic [15:0] TIMER_TOP_RESET      = 16'd39999;
   localparam logic [14:0] SYNC_THRESHOLD_RESET = 15'd4000;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TIMER_TOP      = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SYNC_THRESHOLD = 2'd1;

   // One decoded pulse on its way to the output.
   typedef struct packed {
      logic [3:0]  slot;
      logic [14:0] width_us;
      logic        frame_done;
   } result_type;

   // Status of the queue as the front and back parts see it.
   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

### design/ppmd_front.sv
// Front part of the PPM decoder: accepts edge requests, measures pulse widths,
// counts edges and classifies each request into a channel result, a remainder
// result or none. Depends on ppmd_pkg.
module ppmd_front
   import ppmd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_capture_time,
   input  logic                       csr_valid,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_wdata,
   input  queue_status_type           q_status,
   output logic                       q_push,
   output result_type                 q_push_data
);

   localparam logic [5:0] CHANNEL_LIMIT = 6'(2 * NUM_CHANNELS);
   localparam logic [5:0] REMAINDER_CNT = 6'(2 * NUM_CHANNELS + 2);
   localparam logic [3:0] REMAINDER_SLOT = 4'(NUM_CHANNELS);

   logic [15:0] timer_top_ff;
   logic [14:0] sync_threshold_ff;
   logic        expect_rise_ff, expect_rise_in;
   logic [15:0] rise_time_ff, rise_time_in;
   logic [14:0] last_width_ff, last_width_in;
   logic [4:0]  edge_count_ff, edge_count_in;

   logic        accept;
   logic [15:0] diff;
   logic [4:0]  count;
   logic [5:0]  count_ext;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;

   always_comb begin
      if (rise_time_ff > req_capture_time) begin
         diff = timer_top_ff + 16'd1 + req_capture_time - rise_time_ff;
      end else begin
         diff = req_capture_time - rise_time_ff;
      end

      rise_time_in   = rise_time_ff;
      last_width_in  = last_width_ff;
      if (expect_rise_ff) begin
         rise_time_in   = req_capture_time;
         expect_rise_in = 1'b0;
      end else begin
         last_width_in  = diff[15:1];
         expect_rise_in = 1'b1;
      end

      // A long pulse is the sync gap and restarts slot counting.
      if (last_width_in > sync_threshold_ff) begin
         count = 5'd0;
      end else begin
         count = edge_count_ff + 5'd1;
      end
      count_ext = {1'b0, count};

      edge_count_in          = count;
      q_push                 = 1'b0;
      q_push_data.slot       = count[4:1] - 4'd1;
      q_push_data.width_us   = last_width_in;
      q_push_data.frame_done = 1'b0;
      if (count != 5'd0 && !count[0] && count_ext <= CHANNEL_LIMIT) begin
         q_push = accept;
      end else if (count_ext == REMAINDER_CNT) begin
         q_push                 = accept;
         q_push_data.slot       = REMAINDER_SLOT;
         q_push_data.frame_done = 1'b1;
         edge_count_in          = 5'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_top_ff      <= TIMER_TOP_RESET;
         sync_threshold_ff <= SYNC_THRESHOLD_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TIMER_TOP:      timer_top_ff      <= csr_wdata;
            CSR_SYNC_THRESHOLD: sync_threshold_ff <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         expect_rise_ff <= 1'b1;
         rise_time_ff   <= 16'd0;
         last_width_ff  <= 15'd0;
         edge_count_ff  <= 5'd0;
      end else if (accept) begin
         expect_rise_ff <= expect_rise_in;
         rise_time_ff   <= rise_time_in;
         last_width_ff  <= last_width_in;
         edge_count_ff  <= edge_count_in;
      end
   end

endmodule

### design/ppmd_queue.sv
// Short result queue between the front and back parts of the PPM decoder.
// Depends on ppmd_pkg.
module ppmd_queue
   import ppmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  result_type       push_data,
   input  logic             pop,
   output result_type       head,
   output queue_status_type status
);

   localparam int PTR_WIDTH = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_WIDTH = $clog2(QUEUE_DEPTH + 1);
   localparam logic [CNT_WIDTH-1:0] DEPTH_CNT = CNT_WIDTH'(QUEUE_DEPTH);
   localparam logic [PTR_WIDTH-1:0] LAST_PTR  = PTR_WIDTH'(QUEUE_DEPTH - 1);

   result_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_WIDTH-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_WIDTH-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_WIDTH-1:0]   count_ff, count_in;

   assign head             = entry_ff[rd_ptr_ff];
   assign status.not_empty = count_ff != '0;
   assign status.full      = count_ff == DEPTH_CNT;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/ppmd_back.sv
// Back part of the PPM decoder: takes results from the queue into the output
// register and presents them on the response channel. Depends on ppmd_pkg.
module ppmd_back
   import ppmd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  result_type       q_head,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [3:0]       rsp_slot,
   output logic [14:0]      rsp_width_us,
   output logic             rsp_frame_done
);

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // With a result queued, the output register refills if empty or being taken.
   assign q_pop        = q_status.not_empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = q_pop || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         rsp_data_ff <= q_head;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_slot       = rsp_data_ff.slot;
   assign rsp_width_us   = rsp_data_ff.width_us;
   assign rsp_frame_done = rsp_data_ff.frame_done;

endmodule

### design/ppm_pulse_channel_decoder.sv
// PPM pulse channel decoder: one edge request is accepted per cycle when the
// result queue has room; a decoded pulse reaches rsp_ via the queue and the
// output register. Throughput is one request per cycle, set by the width
// measure and edge count step in the front part. Synchronous active-high
// reset returns the timer top to 39999, the sync threshold to 4000, expects
// a rising edge first and empties the queue and output register.
// Depends on ppmd_pkg, ppmd_front, ppmd_queue and ppmd_back.
module ppm_pulse_channel_decoder
   import ppmd_pkg::*;
#(
   parameter int NUM_CHANNELS = NUM_CHANNELS_DEFAULT
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [15:0]                req_capture_time,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [3:0]                 rsp_slot,
   output logic [14:0]                rsp_width_us,
   output logic                       rsp_frame_done,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [15:0]                csr_wdata
);

   // Configuration writes are always taken; unknown indexes are ignored.
   assign csr_ready = 1'b1;

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   result_type       q_push_data;
   result_type       q_head;

   // The front part measures each pulse and decides whether the request
   // yields a channel or remainder result. It stalls only when the queue is
   // full, so requests keep flowing while a result waits on the output.
   ppmd_front #(
      .NUM_CHANNELS(NUM_CHANNELS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_capture_time(req_capture_time),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_push_data     (q_push_data)
   );

   // The queue decouples the two sides so that each may stall on its own.
   ppmd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_push_data),
      .pop      (q_pop),
      .head     (q_head),
      .status   (q_status)
   );

   // The back part holds the result in the output register until taken.
   ppmd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_head        (q_head),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_slot      (rsp_slot),
      .rsp_width_us  (rsp_width_us),
      .rsp_frame_done(rsp_frame_done)
   );

endmodule

### test/tb_ppm_pulse_channel_decoder.sv
// Testbench for the PPM pulse channel decoder: a table of edge requests with a few hand-worked
// results, then PPM frames with random widths under several timer and threshold settings.
// Depends on ppmd_pkg and the decoder RTL; expected pulses come from a predictor kept here.
module tb_ppm_pulse_channel_decoder
   import ppmd_pkg::*;
();

   localparam int CHANNELS       = NUM_CHANNELS_DEFAULT;
   localparam int REMAINDER_SLOT = CHANNELS;
   localparam int RESET_CYCLES   = 10;
   // Results reach rsp_ through the queue and the output register; this covers that trip.
   localparam int SETTLE_CYCLES  = 8;
   localparam int STALL_LIMIT    = 1000;
   localparam int REPORT_LIMIT   = 10;
   localparam int PHASES         = 6;
   localparam int PHASE_REQUESTS = 84;
   // An index that names no register; writes to it must change nothing.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED = 2'd3;

   // Register settings per phase. Phase 0 keeps the values left by reset.
   localparam logic [15:0] PHASE_TIMER_TOP [PHASES] =
      '{16'd39999, 16'd65535, 16'd1, 16'd2999, 16'd65535, 16'd1};
   localparam logic [15:0] PHASE_THRESHOLD [PHASES] =
      '{16'd4000, 16'hFFFF, 16'd0, 16'd1500, 16'h8000, 16'd32767};

   typedef enum {RECEIVER_STALLS, SENDER_GAPS, FULL_RATE} pace_type;

   // One row of the directed table. Where given is set, the expected result is the one
   // typed in the row; otherwise the predictor supplies it.
   typedef struct packed {
      logic [15:0] capture;
      logic        given;
      logic        produces;
      result_type  pulse;
   } edge_row_type;

   // A rising edge, a falling edge with a wrapped capture that forms a sync pulse, a rising
   // edge that restarts counting on the stored sync width, and then one whole frame whose
   // channels come out on rising edges, ending in the remainder slot.
   localparam edge_row_type DIRECTED_EDGES [23] = '{
      '{16'd0,     1'b1, 1'b0, '{4'd0, 15'd0, 1'b0}},     // first rise after reset
      '{16'd3000,  1'b1, 1'b1, '{4'd0, 15'd1500, 1'b0}},  // channel 0, 3000 counts high
      '{16'd65535, 1'b0, 1'b0, '0},                       // capture above the timer top
      '{16'd0,     1'b0, 1'b0, '0},                       // wraps, long enough to sync
      '{16'd100,   1'b0, 1'b0, '0},                       // rise cleared by the stored sync
      '{16'd1100,  1'b0, 1'b0, '0},
      '{16'd2000,  1'b0, 1'b0, '0},
      '{16'd4000,  1'b0, 1'b0, '0},
      '{16'd6000,  1'b0, 1'b0, '0},
      '{16'd8200,  1'b0, 1'b0, '0},
      '{16'd10000, 1'b0, 1'b0, '0},
      '{16'd12400, 1'b0, 1'b0, '0},
      '{16'd14000, 1'b0, 1'b0, '0},
      '{16'd16600, 1'b0, 1'b0, '0},
      '{16'd18000, 1'b0, 1'b0, '0},
      '{16'd20800, 1'b0, 1'b0, '0},
      '{16'd22000, 1'b0, 1'b0, '0},
      '{16'd25000, 1'b0, 1'b0, '0},
      '{16'd26000, 1'b0, 1'b0, '0},
      '{16'd29200, 1'b0, 1'b0, '0},
      '{16'd30000, 1'b0, 1'b0, '0},
      '{16'd30000, 1'b0, 1'b0, '0},                       // zero high time
      '{16'd39999, 1'b1, 1'b1, '{4'(REMAINDER_SLOT), 15'd0, 1'b1}}  // remainder, frame ends
   };

   logic                       clock;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic [15:0]                req_capture_time = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic [3:0]                 rsp_slot;
   logic [14:0]                rsp_width_us;
   logic                       rsp_frame_done;
   logic                       csr_valid        = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index        = '0;
   logic [15:0]                csr_wdata        = '0;

   // Travel alongside each request so that the checker sees the row it came from.
   logic       req_from_table = 1'b0;
   logic       table_produces = 1'b0;
   result_type table_pulse    = '0;

   // Predictor state and its copy of the registers.
   logic [15:0] top_count     = TIMER_TOP_RESET;
   logic [14:0] sync_level    = SYNC_THRESHOLD_RESET;
   logic        awaiting_rise = 1'b1;
   logic [15:0] rise_stamp    = '0;
   logic [14:0] held_width    = '0;
   logic [4:0]  edge_tally    = '0;

   result_type expected_pulses [$];

   int send_gap_pct   = 0;
   int recv_stall_pct = 0;
   int mismatches     = 0;
   int quiet_cycles   = 0;
   int requests_sent  = 0;
   int pulses_seen    = 0;
   int frames_seen    = 0;
   int timer_pos      = 0;

   ppm_pulse_channel_decoder uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_capture_time (req_capture_time),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_slot         (rsp_slot),
      .rsp_width_us     (rsp_width_us),
      .rsp_frame_done   (rsp_frame_done),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Works out the pulse, if any, that one edge releases, and moves the predictor on.
   function automatic logic decode_edge(input logic [15:0] stamp, output result_type pulse);
      logic [15:0] span;
      pulse = '0;
      if (awaiting_rise) begin
         rise_stamp    = stamp;
         awaiting_rise = 1'b0;
      end else begin
         // A fall that reads lower than its rise has crossed the timer wrap at top + 1.
         // Sixteen-bit arithmetic gives the modulo 2^16 result the block produces.
         if (rise_stamp > stamp)
            span = top_count + 16'd1 + stamp - rise_stamp;
         else
            span = stamp - rise_stamp;
         held_width    = span[15:1];
         awaiting_rise = 1'b1;
      end
      edge_tally = edge_tally + 5'd1;
      // The sync test looks at the last stored width, so rising edges can clear it too.
      if (held_width > sync_level)
         edge_tally = '0;
      if (edge_tally >= 2 && !edge_tally[0] && edge_tally <= 2 * CHANNELS) begin
         pulse.slot     = 4'(edge_tally / 2 - 1);
         pulse.width_us = held_width;
         return 1'b1;
      end
      if (edge_tally == 2 * CHANNELS + 2) begin
         pulse.slot       = 4'(REMAINDER_SLOT);
         pulse.width_us   = held_width;
         pulse.frame_done = 1'b1;
         edge_tally       = '0;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   task automatic note_mismatch(input string what, input int unsigned want,
                                input int unsigned got);
      mismatches++;
      if (mismatches <= REPORT_LIMIT)
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
   endtask

   // The checker follows every handshake at the clock edge, in a fixed order: register
   // writes first, then the request, then the result. It also drives the receiver's stall.
   always @(posedge clock) begin : check_results
      result_type predicted;
      result_type oldest;
      logic       produced;
      logic       moved;
      rsp_stall <= ($urandom_range(99, 0) < recv_stall_pct);
      if (!reset) begin
         moved = 1'b0;
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            case (csr_index)
               CSR_TIMER_TOP:      top_count  = csr_wdata;
               CSR_SYNC_THRESHOLD: sync_level = csr_wdata[14:0];
               default:            ;
            endcase
         end
         if (req_valid && !req_stall) begin
            moved    = 1'b1;
            produced = decode_edge(req_capture_time, predicted);
            if (req_from_table) begin
               produced  = table_produces;
               predicted = table_pulse;
            end
            if (produced)
               expected_pulses.push_back(predicted);
         end
         if (rsp_valid && !rsp_stall) begin
            moved = 1'b1;
            if (expected_pulses.size() == 0) begin
               note_mismatch("unrequested result, slot", 0, rsp_slot);
            end else begin
               oldest = expected_pulses.pop_front();
               if (rsp_slot != oldest.slot)
                  note_mismatch("slot", oldest.slot, rsp_slot);
               if (rsp_width_us != oldest.width_us)
                  note_mismatch("width_us", oldest.width_us, rsp_width_us);
               if (rsp_frame_done != oldest.frame_done)
                  note_mismatch("frame_done", oldest.frame_done, rsp_frame_done);
            end
            pulses_seen++;
            if (rsp_frame_done)
               frames_seen++;
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   // Ends the run if nothing has moved on any channel for too long.
   initial begin
      while (quiet_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("No handshake for %0d cycles, %0d results outstanding",
               STALL_LIMIT, expected_pulses.size());
      $display("Mismatches found");
      $finish;
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         RECEIVER_STALLS: begin
            send_gap_pct   = 15;
            recv_stall_pct = 85;
         end
         SENDER_GAPS: begin
            send_gap_pct   = 85;
            recv_stall_pct = 15;
         end
         default: begin
            send_gap_pct   = 0;
            recv_stall_pct = 0;
         end
      endcase
   endtask

   // Offers one edge request, with random gaps beforehand, and waits until it is taken.
   // Valid stays high on return so that back-to-back requests need no second assignment.
   task automatic send_edge(input logic [15:0] stamp, input logic given = 1'b0,
                            input logic produces = 1'b0, input result_type pulse = '0);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_capture_time <= stamp;
      req_from_table   <= given;
      table_produces   <= produces;
      table_pulse      <= pulse;
      do @(posedge clock); while (!(req_valid && !req_stall));
      requests_sent++;
   endtask

   // Holds valid high across back-to-back writes; the caller lowers it after the last one.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index, input logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!(csr_valid && csr_ready));
   endtask

   // Stops offering requests, waits for every expected pulse and then lets the block settle,
   // since a trailing edge may still be in flight without releasing a pulse.
   task automatic drain;
      req_valid <= 1'b0;
      while (expected_pulses.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One PPM frame on a timer that counts 0..top: a sync pulse, then a run of channel
   // pulses. Most frames are complete; some are cut short or run over.
   task automatic send_frame(input int top, input int thr);
      int period;
      int pulses;
      int high;
      int low;
      int fall_at;
      period = top + 1;
      pulses = ($urandom_range(3, 0) != 0) ? CHANNELS + 1 : $urandom_range(CHANNELS + 4, 1);
      for (int k = 0; k <= pulses; k++) begin
         if (k == 0) begin
            // Sync pulse: just over the threshold, the whole period, or anything between,
            // where the timer period allows a sync at all.
            if (2 * thr + 2 > top)
               high = $urandom_range(top, 0);
            else if ($urandom_range(7, 0) == 0)
               high = 2 * thr + 2;
            else if ($urandom_range(7, 0) == 0)
               high = top;
            else
               high = $urandom_range(top, 2 * thr + 2);
         end else if ($urandom_range(7, 0) == 0) begin
            high = 2 * thr + 1;   // lands exactly on the threshold, so no sync
         end else begin
            high = $urandom_range((2 * thr < top) ? 2 * thr : top, 0);
         end
         low     = $urandom_range(800, 0);
         fall_at = (timer_pos + high) % period;
         send_edge(16'(timer_pos));
         send_edge(16'(fall_at));
         timer_pos = (fall_at + low) % period;
      end
   endtask

   initial begin : stimulus
      int phase_start;
      int gen_top;
      int gen_thr;
      set_pace(RECEIVER_STALLS);
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // The directed table runs on the register values left by reset.
      foreach (DIRECTED_EDGES[i])
         send_edge(DIRECTED_EDGES[i].capture, DIRECTED_EDGES[i].given,
                   DIRECTED_EDGES[i].produces, DIRECTED_EDGES[i].pulse);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         set_pace(p < 2 ? RECEIVER_STALLS : (p < 4 ? SENDER_GAPS : FULL_RATE));
         if (p != 0) begin
            write_csr(CSR_TIMER_TOP, PHASE_TIMER_TOP[p]);
            write_csr(CSR_SYNC_THRESHOLD, PHASE_THRESHOLD[p]);
            if (p == 3)
               write_csr(CSR_UNUSED, 16'hA5A5);
            csr_valid <= 1'b0;
         end
         gen_top     = PHASE_TIMER_TOP[p];
         gen_thr     = PHASE_THRESHOLD[p] & 16'h7FFF;
         timer_pos   = 0;
         phase_start = requests_sent;
         // Mostly well-formed frames; the rest are stray edges anywhere in the 16-bit range,
         // which also knock the rise and fall pairing out of step.
         while (requests_sent - phase_start < PHASE_REQUESTS) begin
            if ($urandom_range(99, 0) < 85)
               send_frame(gen_top, gen_thr);
            else
               repeat ($urandom_range(4, 1)) send_edge(16'($urandom_range(65535, 0)));
         end
         drain();
      end

      $display("Sent %0d edge requests; checked %0d decoded pulses, %0d of them frame ends.",
               requests_sent, pulses_seen, frames_seen);
      $display("Used %0d register settings, both ends of each range, under three paces.",
               PHASES);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
